// ===== hdl/irpw_pkg.sv =====
// Shared types and constants for the IR pulse-width frame receiver.
// No dependencies; imported by ir_pulse_width_frame_receiver_unit.
`timescale 1ns / 1ps

package irpw_pkg;

    // Number of data pulses in one frame, after the start pulse
    localparam int FRAME_BITS = 4;

    // Result word: the last four received bits
    localparam int DATA_W = 4;

    // Width of all configuration registers and of the tick counters
    localparam int CNT_W = 16;

    // Pulse index runs 0 (start pulse) through FRAME_BITS + 1 (frame done)
    localparam int IDX_W = $clog2(FRAME_BITS + 2);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Register reset values
    localparam logic [CNT_W-1:0] START_MIN_RST     = CNT_W'(800);
    localparam logic [CNT_W-1:0] START_MAX_RST     = CNT_W'(1200);
    localparam logic [CNT_W-1:0] BIT_THRESHOLD_RST = CNT_W'(375);
    localparam logic [CNT_W-1:0] GAP_TICKS_RST     = CNT_W'(500);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_MIN     = 2'd0,
        CFG_START_MAX     = 2'd1,
        CFG_BIT_THRESHOLD = 2'd2,
        CFG_GAP_TICKS     = 2'd3
    } cfg_index_t;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_MEASURE = 2'd1,
        PH_GAP     = 2'd2
    } phase_t;

endpackage

// ===== hdl/ir_pulse_width_frame_receiver_unit.sv =====
// Top level of the IR pulse-width frame receiver: input register, phase
// machine with width and gap counters, and result register. Uses irpw_pkg.
`timescale 1ns / 1ps

// One line sample is taken per tick; the block accepts one sample every clock
// cycle unless a result waits on out_ready. A sample is held in the input
// register, then the phase machine judges it and any frame result lands in
// the output register, so out_valid rises once the sample ending the frame
// has passed both registers (a bad start's falling edge, the frame's last gap
// tick or, with a zero gap, its last falling edge). While a result waits on
// out_ready the input register still takes one more sample; the machine
// advances only when the result register is free. Configuration writes take
// effect on the next cycle and should be made while no sample is in flight.
module ir_pulse_width_frame_receiver_unit
    import irpw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration write port
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [CNT_W-1:0]  cfg_data,

    // sample channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              ir_level,

    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] frame_data,
    output logic              frame_error
);

    // configuration registers
    logic [CNT_W-1:0] start_min_reg;
    logic [CNT_W-1:0] start_max_reg;
    logic [CNT_W-1:0] bit_threshold_reg;
    logic [CNT_W-1:0] gap_ticks_reg;

    // input register
    logic             s1_valid_reg;
    logic             s1_level_reg;
    logic             s1_fire;

    // receiver state
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   pulse_count_reg, pulse_count_next;
    logic [CNT_W-1:0]   gap_count_reg, gap_count_next;
    logic [IDX_W-1:0]   pulse_index_reg, pulse_index_next;
    logic [DATA_W-1:0]  shift_data_reg, shift_data_next;

    // result register
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_error_reg;

    // decode helpers
    logic               meas_fall;
    logic               start_bad;
    logic               gap_zero;
    logic [CNT_W-1:0]   gap_count_inc;
    logic               gap_end;
    logic               gap_done;
    logic [IDX_W-1:0]   index_after;
    logic [DATA_W-1:0]  shift_after;
    logic               res_error;
    logic               res_frame;
    logic               res_valid;
    logic               restart;

    //--------------------------------------------------------------------
    // Configuration writes
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg     <= START_MIN_RST;
            start_max_reg     <= START_MAX_RST;
            bit_threshold_reg <= BIT_THRESHOLD_RST;
            gap_ticks_reg     <= GAP_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_START_MIN:     start_min_reg     <= cfg_data;
                CFG_START_MAX:     start_max_reg     <= cfg_data;
                CFG_BIT_THRESHOLD: bit_threshold_reg <= cfg_data;
                CFG_GAP_TICKS:     gap_ticks_reg     <= cfg_data;
                default:           start_min_reg     <= start_min_reg;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Input register: advance when the machine consumes the held sample
    //--------------------------------------------------------------------
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_level_reg <= ir_level;
        end
    end

    //--------------------------------------------------------------------
    // Pulse judging and gap end detection
    //--------------------------------------------------------------------
    assign meas_fall     = (phase_reg == PH_MEASURE) && !s1_level_reg;
    assign start_bad     = (pulse_index_reg == '0) &&
                           ((pulse_count_reg < start_min_reg) ||
                            (pulse_count_reg > start_max_reg));
    assign gap_zero      = (gap_ticks_reg == '0);
    assign gap_count_inc = gap_count_reg + CNT_W'(1);
    assign gap_end       = (phase_reg == PH_GAP) && (gap_count_inc >= gap_ticks_reg);
    assign gap_done      = (meas_fall && !start_bad && gap_zero) || gap_end;

    assign index_after = meas_fall ? (pulse_index_reg + IDX_W'(1)) : pulse_index_reg;
    assign shift_after = (meas_fall && (pulse_index_reg != '0)) ?
                         {shift_data_reg[DATA_W-2:0], (pulse_count_reg > bit_threshold_reg)} :
                         shift_data_reg;

    assign res_error = meas_fall && start_bad;
    assign res_frame = gap_done && (index_after > IDX_W'(FRAME_BITS));
    assign res_valid = res_error || res_frame;
    assign restart   = res_valid;

    //--------------------------------------------------------------------
    // Next phase
    //--------------------------------------------------------------------
    always_comb
    begin
        case (phase_reg)
            PH_MEASURE:
            begin
                if (s1_level_reg)
                    phase_next = PH_MEASURE;
                else if (start_bad || gap_zero)
                    phase_next = PH_WAIT;
                else
                    phase_next = PH_GAP;
            end
            PH_GAP:
            begin
                phase_next = gap_end ? PH_WAIT : PH_GAP;
            end
            default:
            begin
                phase_next = s1_level_reg ? PH_MEASURE : PH_WAIT;
            end
        endcase
    end

    //--------------------------------------------------------------------
    // Counters and shift register
    //--------------------------------------------------------------------
    always_comb
    begin
        pulse_count_next = pulse_count_reg;
        gap_count_next   = gap_count_reg;
        pulse_index_next = index_after;
        shift_data_next  = shift_after;

        case (phase_reg)
            PH_MEASURE:
            begin
                if (s1_level_reg)
                begin
                    if (pulse_count_reg != CNT_MAX)
                        pulse_count_next = pulse_count_reg + CNT_W'(1);
                end
                else
                begin
                    gap_count_next = '0;
                end
            end
            PH_GAP:
            begin
                gap_count_next = gap_end ? '0 : gap_count_inc;
            end
            default:
            begin
                if (s1_level_reg)
                    pulse_count_next = CNT_W'(1);
            end
        endcase

        // drop the frame after any result
        if (restart)
        begin
            pulse_count_next = '0;
            gap_count_next   = '0;
            pulse_index_next = '0;
            shift_data_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            pulse_count_reg <= '0;
            gap_count_reg   <= '0;
            pulse_index_reg <= '0;
            shift_data_reg  <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg       <= phase_next;
            pulse_count_reg <= pulse_count_next;
            gap_count_reg   <= gap_count_next;
            pulse_index_reg <= pulse_index_next;
            shift_data_reg  <= shift_data_next;
        end
    end

    //--------------------------------------------------------------------
    // Result register: load on a consumed sample, clear on transfer
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_valid)
        begin
            out_data_reg  <= res_error ? '0 : shift_after;
            out_error_reg <= res_error;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_data  = out_data_reg;
    assign frame_error = out_error_reg;

`ifndef SYNTHESIS
    // an error result never carries data bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_error) |-> (frame_data == '0))
        else $error("error result with nonzero frame_data");

    // pulse index never passes the frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_index_reg <= IDX_W'(FRAME_BITS + 1)))
        else $error("pulse index out of range");

    // a gap only follows an accepted pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_GAP) |-> (pulse_index_reg != '0))
        else $error("gap phase with start pulse index");

    // waiting always starts with a cleared gap counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> (gap_count_reg == '0))
        else $error("gap counter not cleared while waiting");

    // a produced result is presented on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && res_valid) |=> out_valid)
        else $error("result lost");
`endif

endmodule

// ===== test/ir_frame_checker.sv =====
// Frame checker for the IR pulse-width frame receiver: watches the sample,
// result and configuration ports, predicts each frame and compares it.
// Depends on irpw_pkg.
`timescale 1ns / 1ps

module ir_frame_checker
    import irpw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              ir_level,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DATA_W-1:0] frame_data,
    input  logic              frame_error,
    output int                fail_count,
    output int                frames_pending,
    output int                frames_ok,
    output int                frames_rejected
);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              bad_start;
    } frame_t;

    // Frames predicted but not yet seen on the result port
    frame_t pending_frames[$];

    // Shadow of the configuration registers
    logic [CNT_W-1:0] min_width;
    logic [CNT_W-1:0] max_width;
    logic [CNT_W-1:0] one_threshold;
    logic [CNT_W-1:0] gap_len;

    // Shadow of the receiver state
    phase_t            rx_phase;
    logic [CNT_W-1:0]  width_cnt;
    int                gap_cnt;
    int                bit_idx;
    logic [DATA_W-1:0] bits;

    int mismatches = 0;

    task automatic drop_frame();
        rx_phase  = PH_WAIT;
        width_cnt = '0;
        gap_cnt   = 0;
        bit_idx   = 0;
        bits      = '0;
    endtask

    // End of a gap: hand out the finished frame or go back to watching
    task automatic close_gap();
        frame_t f;
        if (bit_idx > FRAME_BITS) begin
            f.data      = bits;
            f.bad_start = 1'b0;
            pending_frames.push_back(f);
            drop_frame();
        end
        else begin
            rx_phase = PH_WAIT;
            gap_cnt  = 0;
        end
    endtask

    // Advance the shadow receiver by one line sample
    task automatic decode_sample(input logic lvl);
        frame_t f;
        case (rx_phase)
            PH_MEASURE: begin
                if (lvl) begin
                    if (width_cnt != CNT_MAX)
                        width_cnt = width_cnt + CNT_W'(1);
                end
                else if (bit_idx == 0 &&
                         (width_cnt < min_width || width_cnt > max_width)) begin
                    f.data      = '0;
                    f.bad_start = 1'b1;
                    pending_frames.push_back(f);
                    drop_frame();
                end
                else begin
                    if (bit_idx != 0)
                        bits = {bits[DATA_W-2:0], width_cnt > one_threshold};
                    bit_idx = bit_idx + 1;
                    gap_cnt = 0;
                    if (gap_len == '0)
                        close_gap();
                    else
                        rx_phase = PH_GAP;
                end
            end
            PH_GAP: begin
                gap_cnt = gap_cnt + 1;
                if (gap_cnt >= int'(gap_len))
                    close_gap();
            end
            default: begin
                rx_phase = PH_WAIT;
                if (lvl) begin
                    width_cnt = CNT_W'(1);
                    rx_phase  = PH_MEASURE;
                end
            end
        endcase
    endtask

    // Track writes and transfers, compare each result with the oldest frame
    always @(posedge clk or negedge rst_n) begin : watch
        frame_t want;
        if (!rst_n) begin
            min_width     = START_MIN_RST;
            max_width     = START_MAX_RST;
            one_threshold = BIT_THRESHOLD_RST;
            gap_len       = GAP_TICKS_RST;
            drop_frame();
            pending_frames.delete();
            frames_pending  <= 0;
            frames_ok       <= 0;
            frames_rejected <= 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_START_MIN:     min_width     = cfg_data;
                    CFG_START_MAX:     max_width     = cfg_data;
                    CFG_BIT_THRESHOLD: one_threshold = cfg_data;
                    CFG_GAP_TICKS:     gap_len       = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                decode_sample(ir_level);

            if (out_valid && out_ready) begin
                if (pending_frames.size() == 0) begin
                    $error("unexpected result: frame_data %0h frame_error %0b",
                           frame_data, frame_error);
                    mismatches = mismatches + 1;
                end
                else begin
                    want = pending_frames.pop_front();
                    if (frame_data !== want.data) begin
                        $error("frame_data mismatch: expected %0h, actual %0h",
                               want.data, frame_data);
                        mismatches = mismatches + 1;
                    end
                    if (frame_error !== want.bad_start) begin
                        $error("frame_error mismatch: expected %0b, actual %0b",
                               want.bad_start, frame_error);
                        mismatches = mismatches + 1;
                    end
                    if (want.bad_start)
                        frames_rejected <= frames_rejected + 1;
                    else
                        frames_ok <= frames_ok + 1;
                end
            end

            frames_pending <= pending_frames.size();
        end
        fail_count <= mismatches;
    end

endmodule

// ===== test/tb_ir_pulse_width_frame_receiver_unit.sv =====
// Testbench top for ir_pulse_width_frame_receiver_unit: clock, reset, line
// sample and configuration stimulus, result back-pressure and the verdict.
// Depends on irpw_pkg, the unit and ir_frame_checker.
`timescale 1ns / 1ps

module tb_ir_pulse_width_frame_receiver_unit;
    import irpw_pkg::*;

    localparam int SAMPLE_TARGET  = 1450;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [1:0]        cfg_index   = CFG_START_MIN;
    logic [CNT_W-1:0]  cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              ir_level    = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [DATA_W-1:0] frame_data;
    logic              frame_error;

    int fail_count;
    int frames_pending;
    int frames_ok;
    int frames_rejected;

    // Idle and stall percentages, one pair per traffic mix
    int idle_mix[4]  = '{0, 63, 0, 31};
    int stall_mix[4] = '{0, 0, 63, 31};
    int send_idle    = 0;
    int recv_stall   = 0;

    // Register values as last written, used to shape the frames
    int cur_min = 800;
    int cur_max = 1200;
    int cur_thr = 375;
    int cur_gap = 500;

    int bit_widths[FRAME_BITS];
    int total_samples = 0;
    int live_samples  = 0;
    int stall_cycles  = 0;

    always #1 clk = ~clk;

    ir_pulse_width_frame_receiver_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ir_level    (ir_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_data  (frame_data),
        .frame_error (frame_error)
    );

    ir_frame_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .ir_level        (ir_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_data      (frame_data),
        .frame_error     (frame_error),
        .fail_count      (fail_count),
        .frames_pending  (frames_pending),
        .frames_ok       (frames_ok),
        .frames_rejected (frames_rejected)
    );

    // Stall the result side at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    // Abort when no transfer happens for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offer one sample, idling first at random, and hold until the transfer
    task automatic send_tick(input logic lvl, input bit live);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ir_level <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        total_samples = total_samples + 1;
        if (live)
            live_samples = live_samples + 1;
    endtask

    // High pulse of the given width, closed by its falling edge
    task automatic send_pulse(input int width);
        repeat (width) send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
    endtask

    // Ignored ticks after a pulse, filled with random levels
    task automatic send_gap();
        repeat (cur_gap) send_tick(1'($urandom_range(1)), 1'b0);
    endtask

    task automatic send_bits(input int n_data);
        for (int i = 0; i < n_data; i++) begin
            repeat ($urandom_range(2)) send_tick(1'b0, 1'b1);
            send_pulse(bit_widths[i]);
            send_gap();
        end
    endtask

    // Start pulse, then data pulses only if the start falls in the window
    task automatic send_frame(input int start_w, input int n_data);
        send_pulse(start_w);
        if (start_w >= cur_min && start_w <= cur_max) begin
            send_gap();
            send_bits(n_data);
        end
    endtask

    // Drop valid and wait until every frame is out and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles
    task automatic set_regs(input int lo, input int hi, input int thr, input int gap);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_MIN;
        cfg_data  <= CNT_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_START_MAX;
        cfg_data  <= CNT_W'(hi);
        @(posedge clk);
        cfg_index <= CFG_BIT_THRESHOLD;
        cfg_data  <= CNT_W'(thr);
        @(posedge clk);
        cfg_index <= CFG_GAP_TICKS;
        cfg_data  <= CNT_W'(gap);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_min = lo;
        cur_max = hi;
        cur_thr = thr;
        cur_gap = gap;
    endtask

    // Mostly well-formed frames with random widths, some noise and cut frames
    task automatic random_frame();
        int start_w;
        int top_w;
        int n_data;
        top_w = (cur_max < cur_min + 6) ? cur_max : cur_min + 6;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(20, 1)) send_tick(1'($urandom_range(1)), 1'b1);
        else begin
            for (int i = 0; i < FRAME_BITS; i++)
                bit_widths[i] = $urandom_range(2 * cur_thr + 1, 1);
            if (cur_min <= cur_max && $urandom_range(9) < 8)
                start_w = $urandom_range(top_w, cur_min);
            else if (cur_max < 100 && $urandom_range(1) == 1)
                start_w = cur_max + 1 + $urandom_range(2);
            else
                start_w = $urandom_range(cur_min > 1 ? cur_min - 1 : 1, 1);
            n_data = ($urandom_range(7) == 0) ? $urandom_range(FRAME_BITS - 1)
                                              : FRAME_BITS;
            repeat ($urandom_range(3)) send_tick(1'b0, 1'b1);
            send_frame(start_w, n_data);
        end
    endtask

    initial begin
        int lo;
        int hi;
        int blk;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window: a short start pulse is rejected
        send_frame(5, 0);

        // Zero gap: frame comes out on the last falling edge
        settle();
        set_regs(3, 5, 2, 0);
        bit_widths = '{1, 3, 3, 3};
        send_frame(3, 4);
        send_frame(5, 4);
        send_frame(6, 0);
        send_frame(2, 0);

        // Inverted window and an empty window reject every start pulse
        settle();
        set_regs(6, 3, 2, 1);
        send_frame(3, 0);
        send_frame(6, 0);
        settle();
        set_regs(0, 0, 0, 1);
        send_frame(1, 0);

        // Widest window with a zero threshold: all ones
        settle();
        set_regs(0, 65535, 0, 1);
        bit_widths = '{1, 1, 1, 1};
        send_frame(1, 4);

        // Full-scale start minimum rejects, full-scale threshold gives zeros
        settle();
        set_regs(65535, 65535, 65535, 1);
        send_frame(3, 0);
        settle();
        set_regs(0, 65535, 65535, 1);
        bit_widths = '{2, 1, 3, 2};
        send_frame(4, 4);

        // Longest gap, cut short by a write while the frame is open
        settle();
        set_regs(1, 4, 1, 65535);
        send_pulse(2);
        repeat (5) send_tick(1'b0, 1'b0);
        settle();
        set_regs(1, 4, 1, 2);
        bit_widths = '{2, 1, 2, 1};
        send_bits(4);

        // Random settings, cycling through the traffic mixes
        blk = 0;
        while (total_samples < SAMPLE_TARGET) begin
            settle();
            lo = $urandom_range(6, 1);
            hi = lo + $urandom_range(6);
            if ($urandom_range(7) == 0)
                hi = lo - 1;
            else if ($urandom_range(7) == 0)
                hi = 65535;
            set_regs(lo, hi, $urandom_range(6), $urandom_range(4));
            send_idle  = idle_mix[blk % 4];
            recv_stall = stall_mix[blk % 4];
            repeat (6) random_frame();
            blk = blk + 1;
        end

        settle();
        $display("tb: %0d line samples sent (%0d outside gaps), %0d frames decoded, %0d rejected",
                 total_samples, live_samples, frames_ok, frames_rejected);
        $display("tb: %0d random setting blocks plus window, threshold and gap edge runs",
                 blk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
